>>> rtl/sps_pkg.sv
package sps_pkg;

    // register file layout
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned CFG_IDX_W  = 3;

    localparam logic [CFG_IDX_W-1:0] REG_MOTOR_MODE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURRENT_SCALE = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_LEVEL_COUNT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ACTIVE_LOW    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_REVERSE_DIR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_STEP_DELAY    = 3'd5;

    // motor modes
    localparam logic [1:0] MODE_HOLD = 2'd0;
    localparam logic [1:0] MODE_FULL = 2'd1;
    localparam logic [1:0] MODE_HALF = 2'd2;

    // request kinds
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_MOVE = 1'b1;

    // phase counts per mode
    localparam logic [3:0] PHASES_HOLD = 4'd1;
    localparam logic [3:0] PHASES_FULL = 4'd4;
    localparam logic [3:0] PHASES_HALF = 4'd8;

    // full-current scale and one-third threshold on scale * top
    localparam logic [8:0]  SCALE_FULL   = 9'd256;
    localparam logic [10:0] THIRD_THRESH = 11'd768;

    // phase tables, bit i is entry i
    localparam logic [3:0] FULL_DIR_A  = 4'b1001;
    localparam logic [3:0] FULL_DIR_B  = 4'b0011;
    localparam logic [7:0] HALF_THIRD_A = 8'b1000_1000;
    localparam logic [7:0] HALF_THIRD_B = 8'b0010_0010;
    localparam logic [7:0] HALF_DIR_A  = 8'b0111_1000;
    localparam logic [7:0] HALF_DIR_B  = 8'b1110_0001;

    // holding mode direction bits
    localparam logic HOLD_DIR_A = 1'b0;
    localparam logic HOLD_DIR_B = 1'b1;

    typedef struct packed {
        logic [1:0]  motor_mode;
        logic [8:0]  current_scale;
        logic [2:0]  level_count;
        logic        active_low;
        logic        reverse_dir;
        logic [31:0] step_delay;
    } cfg_t;

    typedef struct packed {
        logic        req_type;
        logic [15:0] step_amount;
        logic        backwards;
    } item_t;

    typedef struct packed {
        logic [1:0]         coil_a_level;
        logic [1:0]         coil_b_level;
        logic               phase_a_dir;
        logic               phase_b_dir;
        logic               stepped;
        logic               busy_res;
        logic signed [31:0] position_now;
        logic signed [31:0] pending_now;
    } result_t;

    // clamp a 34-bit signed sum to the signed 32-bit range
    function automatic logic [31:0] sat32(input logic [33:0] v);
        logic [31:0] r;
        if (v[33:31] == 3'b000 || v[33:31] == 3'b111) begin
            r = v[31:0];
        end else if (v[33]) begin
            r = 32'h8000_0000;
        end else begin
            r = 32'h7FFF_FFFF;
        end
        return r;
    endfunction

endpackage

>>> rtl/sps_cfg_regs.sv
module sps_cfg_regs (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sps_pkg::CFG_IDX_W-1:0] cfg_wr_index,
    input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    output sps_pkg::cfg_t                 cfg,
    output logic                          mode_wr
);
    import sps_pkg::*;

    cfg_t cfg_reg;

    assign cfg     = cfg_reg;
    assign mode_wr = cfg_wr_en && (cfg_wr_index == REG_MOTOR_MODE);

    // register writes, unknown indexes ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.motor_mode    <= MODE_HOLD;
            cfg_reg.current_scale <= 9'd0;
            cfg_reg.level_count   <= 3'd4;
            cfg_reg.active_low    <= 1'b0;
            cfg_reg.reverse_dir   <= 1'b0;
            cfg_reg.step_delay    <= 32'd1000;
        end else if (cfg_wr_en) begin
            unique case (cfg_wr_index)
                REG_MOTOR_MODE:    cfg_reg.motor_mode    <= cfg_wr_data[1:0];
                REG_CURRENT_SCALE: cfg_reg.current_scale <= cfg_wr_data[8:0];
                REG_LEVEL_COUNT:   cfg_reg.level_count   <= cfg_wr_data[2:0];
                REG_ACTIVE_LOW:    cfg_reg.active_low    <= cfg_wr_data[0];
                REG_REVERSE_DIR:   cfg_reg.reverse_dir   <= cfg_wr_data[0];
                REG_STEP_DELAY:    cfg_reg.step_delay    <= cfg_wr_data[31:0];
                default: begin
                end
            endcase
        end
    end

endmodule

>>> rtl/sps_coil_map.sv
module sps_coil_map (
    input  sps_pkg::cfg_t cfg,
    input  logic [2:0]    phase_idx,
    output logic [1:0]    coil_a_level,
    output logic [1:0]    coil_b_level,
    output logic          phase_a_dir,
    output logic          phase_b_dir
);
    import sps_pkg::*;

    logic [8:0]  scale;
    logic [1:0]  top;
    logic [10:0] prod;
    logic [1:0]  lvl_full;
    logic [1:0]  lvl_third;
    logic [1:0]  out_full;
    logic [1:0]  out_third;
    logic        third_a;
    logic        third_b;

    // clamp scale and level count, then scale the top level
    always_comb begin
        scale = (cfg.current_scale > SCALE_FULL) ? SCALE_FULL : cfg.current_scale;
        if (cfg.level_count == 3'd0) begin
            top = 2'd0;
        end else if (cfg.level_count > 3'd4) begin
            top = 2'd3;
        end else begin
            top = 2'(cfg.level_count - 3'd1);
        end
        prod      = {2'b00, scale} * {9'd0, top};
        lvl_full  = prod[9:8];
        lvl_third = (prod >= THIRD_THRESH) ? 2'd1 : 2'd0;
        out_full  = cfg.active_low ? 2'(top - lvl_full)  : lvl_full;
        out_third = cfg.active_low ? 2'(top - lvl_third) : lvl_third;
    end

    // phase table lookup
    always_comb begin
        third_a = 1'b0;
        third_b = 1'b0;
        unique case (cfg.motor_mode)
            MODE_FULL: begin
                phase_a_dir = FULL_DIR_A[phase_idx[1:0]];
                phase_b_dir = FULL_DIR_B[phase_idx[1:0]];
            end
            MODE_HALF: begin
                third_a     = HALF_THIRD_A[phase_idx];
                third_b     = HALF_THIRD_B[phase_idx];
                phase_a_dir = HALF_DIR_A[phase_idx];
                phase_b_dir = HALF_DIR_B[phase_idx];
            end
            default: begin
                phase_a_dir = HOLD_DIR_A;
                phase_b_dir = HOLD_DIR_B;
            end
        endcase
        coil_a_level = third_a ? out_third : out_full;
        coil_b_level = third_b ? out_third : out_full;
    end

endmodule

>>> rtl/sps_step_core.sv
module sps_step_core (
    input  logic             aclk,
    input  logic             aresetn,
    input  sps_pkg::cfg_t    cfg,
    input  logic             mode_wr,
    input  logic             fire,
    input  sps_pkg::item_t   item,
    output sps_pkg::result_t result
);
    import sps_pkg::*;

    logic [2:0]  phase_idx_reg;
    logic [2:0]  phase_idx_next;
    logic [31:0] pending_reg;
    logic [31:0] pending_next;
    logic [31:0] elapsed_reg;
    logic [31:0] elapsed_next;
    logic [31:0] position_reg;
    logic [31:0] position_next;

    logic [31:0] elapsed_inc;
    logic [16:0] half_up;
    logic [17:0] mag_div;
    logic [17:0] mag_pos;
    logic [33:0] div_s;
    logic [33:0] pos_s;
    logic [31:0] pending_cmd;
    logic [31:0] elapsed_cmd;
    logic [32:0] wait_ticks;
    logic        busy;
    logic        go;
    logic        sback;
    logic        down;
    logic [3:0]  phases;
    logic [3:0]  idx_up;
    logic [3:0]  idx_wide;

    // move amount per mode, signed by direction
    always_comb begin
        half_up = {1'b0, item.step_amount} + 17'd1;
        unique case (cfg.motor_mode)
            MODE_FULL: begin
                mag_div = {2'b00, half_up[16:1]};
                mag_pos = {1'b0, half_up[16:1], 1'b0};
            end
            MODE_HALF: begin
                mag_div = {2'b00, item.step_amount};
                mag_pos = {2'b00, item.step_amount};
            end
            default: begin
                mag_div = 18'd0;
                mag_pos = 18'd0;
            end
        endcase
        div_s = item.backwards ? 34'(-{16'd0, mag_div}) : {16'd0, mag_div};
        pos_s = item.backwards ? 34'(-{16'd0, mag_pos}) : {16'd0, mag_pos};
    end

    // tick or command update, then the step check
    always_comb begin
        elapsed_inc = (elapsed_reg == '1) ? elapsed_reg : elapsed_reg + 32'd1;
        if (item.req_type == REQ_MOVE) begin
            pending_cmd   = sat32({{2{pending_reg[31]}}, pending_reg} + div_s);
            position_next = sat32({{2{position_reg[31]}}, position_reg} + pos_s);
            elapsed_cmd   = elapsed_reg;
        end else begin
            pending_cmd   = pending_reg;
            position_next = position_reg;
            elapsed_cmd   = elapsed_inc;
        end

        wait_ticks = (cfg.motor_mode == MODE_HALF) ?
                     (({1'b0, cfg.step_delay} + 33'd1) >> 1) : {1'b0, cfg.step_delay};
        busy  = pending_cmd != 32'd0;
        go    = busy && ({1'b0, elapsed_cmd} >= wait_ticks);
        sback = pending_cmd[31];
        down  = sback ^ cfg.reverse_dir;

        pending_next = pending_cmd;
        elapsed_next = elapsed_cmd;
        if (go) begin
            pending_next = sback ? pending_cmd + 32'd1 : pending_cmd - 32'd1;
            elapsed_next = 32'd0;
        end
    end

    // phase index walk with wrap-around
    always_comb begin
        unique case (cfg.motor_mode)
            MODE_FULL: phases = PHASES_FULL;
            MODE_HALF: phases = PHASES_HALF;
            default:   phases = PHASES_HOLD;
        endcase
        idx_wide = {1'b0, phase_idx_reg};
        idx_up   = idx_wide + 4'd1;
        phase_idx_next = phase_idx_reg;
        if (go) begin
            if (!down) begin
                phase_idx_next = (idx_up >= phases) ? 3'd0 : idx_up[2:0];
            end else if (phase_idx_reg == 3'd0 || idx_wide >= phases) begin
                phase_idx_next = 3'(phases - 4'd1);
            end else begin
                phase_idx_next = phase_idx_reg - 3'd1;
            end
        end
    end

    // counter state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_idx_reg <= 3'd0;
            pending_reg   <= 32'd0;
            elapsed_reg   <= '1;
            position_reg  <= 32'd0;
        end else if (mode_wr) begin
            phase_idx_reg <= 3'd0;
        end else if (fire) begin
            phase_idx_reg <= phase_idx_next;
            pending_reg   <= pending_next;
            elapsed_reg   <= elapsed_next;
            position_reg  <= position_next;
        end
    end

    sps_coil_map u_coil_map (
        .cfg          (cfg),
        .phase_idx    (phase_idx_next),
        .coil_a_level (result.coil_a_level),
        .coil_b_level (result.coil_b_level),
        .phase_a_dir  (result.phase_a_dir),
        .phase_b_dir  (result.phase_b_dir)
    );

    assign result.stepped      = go;
    assign result.busy_res     = busy;
    assign result.position_now = position_next;
    assign result.pending_now  = pending_next;

endmodule

>>> rtl/stepper_phase_sequencer_unit.sv
// Full/half step indexer for a two-phase stepper. Each transfer on the s_ side is either a
// time tick or a move command; every one gives exactly one result on the m_ side with the
// coil levels and directions, whether a step was taken, and the saturating position and
// pending counts. One item is taken per clock unless m_ready stalls the result register. An
// input register feeds the counter update and phase table lookup, which are combinational
// into the result register; that update of the pending, tick and phase counters lets the next
// item follow straight behind. Configuration must be written through cfg_wr_* while no item
// is in flight (the block does not enforce it); a motor_mode write clears the phase index.
module stepper_phase_sequencer_unit (
    input  logic                           aclk,
    input  logic                           aresetn,

    input  logic                           cfg_wr_en,
    input  logic [sps_pkg::CFG_IDX_W-1:0]  cfg_wr_index,
    input  logic [sps_pkg::CFG_DATA_W-1:0] cfg_wr_data,

    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_req_type,
    input  logic [15:0]                    s_step_amount,
    input  logic                           s_backwards,

    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [1:0]                     m_coil_a_level,
    output logic [1:0]                     m_coil_b_level,
    output logic                           m_phase_a_dir,
    output logic                           m_phase_b_dir,
    output logic                           m_stepped,
    output logic                           m_busy_res,
    output logic signed [31:0]             m_position_now,
    output logic signed [31:0]             m_pending_now
);
    import sps_pkg::*;

    cfg_t    cfg;
    logic    mode_wr;
    logic    in_valid_reg;
    item_t   in_item_reg;
    logic    out_valid_reg;
    result_t out_res_reg;
    result_t result;
    logic    advance;

    sps_cfg_regs u_cfg_regs (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_index (cfg_wr_index),
        .cfg_wr_data  (cfg_wr_data),
        .cfg          (cfg),
        .mode_wr      (mode_wr)
    );

    // item moves on when the result register is free or being emptied
    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    // input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_item_reg.req_type    <= s_req_type;
            in_item_reg.step_amount <= s_step_amount;
            in_item_reg.backwards   <= s_backwards;
        end
    end

    sps_step_core u_step_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .mode_wr (mode_wr),
        .fire    (advance),
        .item    (in_item_reg),
        .result  (result)
    );

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_res_reg <= result;
        end
    end

    assign m_valid        = out_valid_reg;
    assign m_coil_a_level = out_res_reg.coil_a_level;
    assign m_coil_b_level = out_res_reg.coil_b_level;
    assign m_phase_a_dir  = out_res_reg.phase_a_dir;
    assign m_phase_b_dir  = out_res_reg.phase_b_dir;
    assign m_stepped      = out_res_reg.stepped;
    assign m_busy_res     = out_res_reg.busy_res;
    assign m_position_now = out_res_reg.position_now;
    assign m_pending_now  = out_res_reg.pending_now;

endmodule
